>>> rtl/pbsaw_pkg.sv
// pbsaw_pkg: widths and fixed-point constants of the PolyBLEP sawtooth oscillator.
// No dependencies; used by polyblep_sawtooth_oscillator.
package pbsaw_pkg;
	localparam int CFG_W          = 32;  // inv_sample_rate, value / 2^40
	localparam int FREQ_W         = 24;  // freq, unsigned Q16.8
	localparam int PROD_FRAC      = 48;  // fraction bits of freq * inv_sample_rate
	localparam int RATIO_BITS     = 16;  // BLEP ratio, Q0.16
	localparam int PHASE_BITS_DEF = 32;
	localparam int OUT_BITS_DEF   = 24;
endpackage

>>> rtl/polyblep_sawtooth_oscillator.sv
// polyblep_sawtooth_oscillator: band-limited falling sawtooth, PolyBLEP corrected.
// Depends on pbsaw_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall / freq): one frequency item per sample.
//   Output channel (out_valid / out_stall / sample): one signed sample per item.
//   Config: cfg_wr_en with cfg_wr_data writes inv_sample_rate; write it only
//   while the block is idle.
// Timing:
//   A bit-serial shift-add multiplier forms the increment, then the update
//   step tests the wrap region and advances the phase. Near the wrap a
//   restoring divider forms the ratio one quotient bit at a time, and the same
//   multiplier squares the ratio. The sample is registered in the finish
//   step once the output register is free; the next item is taken only
//   after the block has returned to idle.
// Reset:
//   arst_n clears phase, inv_sample_rate, the sequencer state and the output valid flag.
// Stalls:
//   The output register holds a result while out_stall is high; a new item
//   may be taken and computed meanwhile, and it waits in its last step until
//   the output register frees up.
module polyblep_sawtooth_oscillator #(
	parameter int PHASE_BITS = pbsaw_pkg::PHASE_BITS_DEF,
	parameter int OUT_BITS   = pbsaw_pkg::OUT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [pbsaw_pkg::CFG_W-1:0]   cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [pbsaw_pkg::FREQ_W-1:0]  freq,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [OUT_BITS-1:0]    sample
);
	import pbsaw_pkg::*;

	localparam int PB     = PHASE_BITS;
	localparam int OB     = OUT_BITS;
	localparam int FO     = OB - 1;
	localparam int ACC_W  = CFG_W + FREQ_W;
	localparam int INC_LO = PROD_FRAC - PB;
	localparam int INCW_W = ACC_W - INC_LO;
	localparam int RW     = (PB > OB) ? PB : OB;
	localparam int SH_R   = (PB >= OB) ? PB - OB : 0;
	localparam int SH_L   = (PB >= OB) ? 0 : OB - PB;
	localparam int SQ_W   = 2 * RATIO_BITS + 1;
	localparam int SQ_SH  = 2 * RATIO_BITS - FO;
	localparam int VW     = OB + 2;
	localparam int CNT_W  = $clog2(FREQ_W);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_CALC = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_SQR  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	logic [2:0]              state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [CFG_W-1:0]        isr_q;
	logic [PB-1:0]           phase_q;
	logic [ACC_W-1:0]        acc_q;
	logic [CFG_W-1:0]        mcand_q;
	logic [FREQ_W-1:0]       mplier_q;
	logic [PB-1:0]           inc_q;
	logic [PB-1:0]           rem_q;
	logic [RATIO_BITS-1:0]   quo_q;
	logic                    neg_q;
	logic signed [OB:0]      base_q;
	logic                    out_valid_q;
	logic signed [OB-1:0]    sample_q;

	// shift-add multiplier step, one multiplier bit per cycle
	logic [CFG_W:0]          mul_sum;
	logic [ACC_W-1:0]        acc_n;
	assign mul_sum = {1'b0, acc_q[ACC_W-1:FREQ_W]}
		+ {1'b0, (mplier_q[0] ? mcand_q : {CFG_W{1'b0}})};
	assign acc_n = {mul_sum, acc_q[FREQ_W-1:1]};

	// increment from the product, saturated just below 1.0
	logic [INCW_W-1:0]       inc_wide;
	logic [PB-1:0]           inc_c;
	assign inc_wide = acc_q[ACC_W-1:INC_LO];
	assign inc_c = (|inc_wide[INCW_W-1:PB]) ? {PB{1'b1}} : inc_wide[PB-1:0];

	// wrap-region tests and next phase
	logic [PB:0]             psum;
	logic                    case_a, case_b;
	assign psum   = {1'b0, phase_q} + {1'b0, inc_c};
	assign case_a = phase_q < inc_c;
	assign case_b = psum[PB] && (|psum[PB-1:0]);

	// 2*phase at OB-1 fraction bits; the naive ramp 1 - 2*phase is formed in base_q
	logic [RW-1:0]           p_ext;
	logic [OB-1:0]           ramp;
	assign p_ext = RW'(phase_q);
	assign ramp  = OB'((p_ext >> SH_R) << SH_L);

	// restoring division step, one quotient bit per cycle
	logic [PB:0]             dv_t, dv_d;
	logic                    dv_ge;
	logic [PB-1:0]           rem_n;
	logic [RATIO_BITS-1:0]   quo_n;
	logic [RATIO_BITS:0]     w_c;
	assign dv_t  = {rem_q, 1'b0};
	assign dv_ge = dv_t >= {1'b0, inc_q};
	assign dv_d  = dv_t - {1'b0, inc_q};
	assign rem_n = dv_ge ? dv_d[PB-1:0] : dv_t[PB-1:0];
	assign quo_n = {quo_q[RATIO_BITS-2:0], dv_ge};
	assign w_c   = {1'b1, {RATIO_BITS{1'b0}}} - {1'b0, quo_n};

	// final sum and saturation
	logic [OB-1:0]           corr;
	logic signed [VW-1:0]    val;
	logic signed [VW-1:0]    lim_hi, lim_lo;
	logic signed [OB-1:0]    sat_val;
	assign corr   = OB'(acc_q[SQ_W-1:0] >> SQ_SH);
	assign val    = neg_q ? (VW'(base_q) - $signed({2'b00, corr}))
	                      : (VW'(base_q) + $signed({2'b00, corr}));
	assign lim_hi = (VW'(1) <<< FO) - VW'(1);
	assign lim_lo = -(VW'(1) <<< FO);
	always_comb begin
		priority if (val > lim_hi) begin
			sat_val = OB'(lim_hi);
		end else if (val < lim_lo) begin
			sat_val = OB'(lim_lo);
		end else begin
			sat_val = OB'(val);
		end
	end

	logic in_acc, out_free;
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			isr_q <= '0;
		end else if (cfg_wr_en) begin
			isr_q <= cfg_wr_data;
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// output flag: loaded from the finish step, cleared when taken
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_MUL;
						cnt_q   <= '0;
					end
				end
				ST_MUL: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(FREQ_W - 1)) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					phase_q <= psum[PB-1:0];
					cnt_q   <= '0;
					state_q <= (case_a || case_b) ? ST_DIV : ST_FIN;
				end
				ST_DIV: begin
					if (cnt_q == CNT_W'(RATIO_BITS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_SQR;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_SQR: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(FREQ_W - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					acc_q    <= '0;
					mcand_q  <= isr_q;
					mplier_q <= freq;
				end
			end
			ST_MUL, ST_SQR: begin
				acc_q    <= acc_n;
				mplier_q <= mplier_q >> 1;
			end
			ST_CALC: begin
				inc_q  <= inc_c;
				neg_q  <= case_a;
				base_q <= (($signed((OB + 1)'(1))) <<< FO) - $signed({1'b0, ramp});
				rem_q  <= case_a ? phase_q : PB'(-phase_q);
				quo_q  <= '0;
				acc_q  <= '0;
			end
			ST_DIV: begin
				rem_q <= rem_n;
				quo_q <= quo_n;
				if (cnt_q == CNT_W'(RATIO_BITS - 1)) begin
					acc_q    <= '0;
					mcand_q  <= CFG_W'(w_c);
					mplier_q <= FREQ_W'(w_c);
				end
			end
			ST_FIN: begin
				if (out_free) begin
					sample_q <= sat_val;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign sample    = sample_q;

`ifndef ASSERT_OFF
	a_accept_starts_mul: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_MUL))
		else $error("accepted item did not start the multiply");

	a_phase_only_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(state_q == ST_CALC) |-> $stable(phase_q))
		else $error("phase changed outside the update step");

	a_valid_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result appeared without a finish step");

	a_rem_below_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < inc_q))
		else $error("divider remainder not below the increment");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(sample_q)))
		else $error("stalled result was overwritten");
`endif

endmodule
